[design/udp_header_extractor_assert.svh]
// Assertion helpers shared by the extractor modules.
`ifndef UDP_HEADER_EXTRACTOR_ASSERT_SVH
`define UDP_HEADER_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UHX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("uhx same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define UHX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("uhx next-cycle check failed");

`endif

[design/uhx_pkg.sv]
package uhx_pkg;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TRUNC     = 2'd1,
		ST_SHORT_UDP = 2'd2,
		ST_BAD_IHL   = 2'd3
	} status_t;

	// Link type tags carried in the first frame byte
	localparam logic [7:0] TAG_COOKED = 8'h00;
	localparam logic [7:0] TAG_LOOP   = 8'h02;

	localparam logic [4:0] LINK_COOKED_BYTES = 5'd16;
	localparam logic [4:0] LINK_LOOP_BYTES   = 5'd4;
	localparam logic [4:0] LINK_ETH_BYTES    = 5'd14;

	localparam logic [3:0] MIN_IHL       = 4'd5;
	localparam logic [6:0] UDP_HDR_BYTES = 7'd8;

	// Byte index within the UDP header
	localparam logic [2:0] UDP_SRC_HI = 3'd0;
	localparam logic [2:0] UDP_SRC_LO = 3'd1;
	localparam logic [2:0] UDP_DST_HI = 3'd2;
	localparam logic [2:0] UDP_DST_LO = 3'd3;
	localparam logic [2:0] UDP_LEN_HI = 3'd4;
	localparam logic [2:0] UDP_LEN_LO = 3'd5;
	localparam logic [2:0] UDP_LAST   = 3'd7;

	typedef struct packed {
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [6:0]  payload_offset;
		logic [15:0] payload_size;
		status_t     status;
	} result_t;

endpackage

[design/udp_header_extractor.sv]
// A result is registered in the output register from the byte held in the input register,
// so it passes through both registers before its output transfer.
// Throughput: one frame byte per cycle; at most one result per frame.
// A result waiting for out_ready stalls the input once the input register is full.
// Reset (arst_n low, asynchronous) empties both stages and returns the parser
// to the start of a frame.
`include "udp_header_extractor_assert.svh"

module udp_header_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  frame_byte,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [6:0]  payload_offset,
	output logic [15:0] payload_size,
	output logic [1:0]  status
);

	logic [7:0]        byte_s1;
	logic              end_s1;
	logic              valid_s1;
	logic              advance;
	logic              hit;
	uhx_pkg::result_t  res;
	uhx_pkg::result_t  res_q;
	logic              out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= frame_byte;
			end_s1  <= frame_end;
		end
	end

	uhx_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.frame_byte (byte_s1),
		.frame_end  (end_s1),
		.hit        (hit),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign source_port    = res_q.source_port;
	assign dest_port      = res_q.dest_port;
	assign payload_offset = res_q.payload_offset;
	assign payload_size   = res_q.payload_size;
	assign status         = res_q.status;

	`UHX_ASSERT_NOW(a_trunc_zero, clk, arst_n,
		out_valid_q && res_q.status == uhx_pkg::ST_TRUNC,
		res_q.source_port == 16'd0 && res_q.payload_offset == 7'd0 && res_q.payload_size == 16'd0)
	`UHX_ASSERT_NOW(a_ihl_zero, clk, arst_n,
		out_valid_q && res_q.status == uhx_pkg::ST_BAD_IHL,
		res_q.dest_port == 16'd0 && res_q.payload_offset == 7'd0 && res_q.payload_size == 16'd0)
	`UHX_ASSERT_NOW(a_ok_offset, clk, arst_n,
		out_valid_q && (res_q.status == uhx_pkg::ST_OK || res_q.status == uhx_pkg::ST_SHORT_UDP),
		res_q.payload_offset >= 7'd32 && res_q.payload_offset <= 7'd84)
	`UHX_ASSERT_NEXT(a_result_loaded, clk, arst_n, advance && hit, out_valid_q)

endmodule

[design/uhx_parser.sv]
`include "udp_header_extractor_assert.svh"

module uhx_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        frame_byte,
	input  logic              frame_end,
	output logic              hit,
	output uhx_pkg::result_t  res
);

	logic [6:0]  pos_q, pos_d;
	logic [4:0]  link_q, link_d;
	logic [5:0]  ip_q, ip_d;
	logic [15:0] sp_q, sp_d;
	logic [15:0] dp_q, dp_d;
	logic [15:0] len_q, len_d;
	logic        given_q, given_d;

	logic [6:0]  udp_start;
	logic [6:0]  udp_idx;
	logic        in_udp;

	always_comb begin
		udp_start = {2'b00, link_q} + {1'b0, ip_q};
		udp_idx   = pos_q - udp_start;
		in_udp    = (pos_q >= udp_start) && (udp_idx[6:3] == 4'd0);

		pos_d   = pos_q;
		link_d  = link_q;
		ip_d    = ip_q;
		sp_d    = sp_q;
		dp_d    = dp_q;
		len_d   = len_q;
		given_d = given_q;
		hit     = 1'b0;
		res     = '0;

		if (!given_q) begin
			if (pos_q == 7'd0) begin
				if (frame_byte == uhx_pkg::TAG_COOKED) begin
					link_d = uhx_pkg::LINK_COOKED_BYTES;
				end else if (frame_byte == uhx_pkg::TAG_LOOP) begin
					link_d = uhx_pkg::LINK_LOOP_BYTES;
				end else begin
					link_d = uhx_pkg::LINK_ETH_BYTES;
				end
			end else if (pos_q == {2'b00, link_q}) begin
				ip_d = {frame_byte[3:0], 2'b00};
				if (frame_byte[3:0] < uhx_pkg::MIN_IHL) begin
					hit        = 1'b1;
					res.status = uhx_pkg::ST_BAD_IHL;
				end
			end else if (pos_q > {2'b00, link_q} && in_udp) begin
				case (udp_idx[2:0])
					uhx_pkg::UDP_SRC_HI: sp_d  = {frame_byte, 8'h00};
					uhx_pkg::UDP_SRC_LO: sp_d  = {sp_q[15:8], frame_byte};
					uhx_pkg::UDP_DST_HI: dp_d  = {frame_byte, 8'h00};
					uhx_pkg::UDP_DST_LO: dp_d  = {dp_q[15:8], frame_byte};
					uhx_pkg::UDP_LEN_HI: len_d = {frame_byte, 8'h00};
					uhx_pkg::UDP_LEN_LO: len_d = {len_q[15:8], frame_byte};
					uhx_pkg::UDP_LAST: begin
						hit                = 1'b1;
						res.source_port    = sp_q;
						res.dest_port      = dp_q;
						res.payload_offset = udp_start + uhx_pkg::UDP_HDR_BYTES;
						if (len_q < {9'd0, uhx_pkg::UDP_HDR_BYTES}) begin
							res.status = uhx_pkg::ST_SHORT_UDP;
						end else begin
							res.payload_size = len_q - {9'd0, uhx_pkg::UDP_HDR_BYTES};
							res.status       = uhx_pkg::ST_OK;
						end
					end
					default: ;
				endcase
			end

			// frame closed before its header was complete
			if (!hit && frame_end) begin
				hit        = 1'b1;
				res        = '0;
				res.status = uhx_pkg::ST_TRUNC;
			end

			if (hit) begin
				given_d = 1'b1;
			end else begin
				pos_d = pos_q + 7'd1;
			end
		end

		// last byte of a frame: start over
		if (frame_end) begin
			pos_d   = '0;
			link_d  = '0;
			ip_d    = '0;
			sp_d    = '0;
			dp_d    = '0;
			len_d   = '0;
			given_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			link_q  <= '0;
			ip_q    <= '0;
			sp_q    <= '0;
			dp_q    <= '0;
			len_q   <= '0;
			given_q <= 1'b0;
		end else if (step) begin
			pos_q   <= pos_d;
			link_q  <= link_d;
			ip_q    <= ip_d;
			sp_q    <= sp_d;
			dp_q    <= dp_d;
			len_q   <= len_d;
			given_q <= given_d;
		end
	end

	`UHX_ASSERT_NEXT(a_end_clears, clk, arst_n, step && frame_end, pos_q == 7'd0 && !given_q)
	`UHX_ASSERT_NEXT(a_hold_after_result, clk, arst_n, step && given_q && !frame_end,
		given_q && $stable(pos_q))
	`UHX_ASSERT_NOW(a_single_result, clk, arst_n, given_q, !hit)

endmodule

[dv/tb_udp_header_extractor.sv]
`timescale 1ns / 100ps

module tb_udp_header_extractor;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 1850;

	typedef struct {
		logic [7:0]       data;
		logic             last;
		bit               typed;
		uhx_pkg::result_t want;
	} stim_row_t;

	localparam uhx_pkg::result_t TRUNC_R = '{16'd0, 16'd0, 7'd0, 16'd0, uhx_pkg::ST_TRUNC};
	localparam uhx_pkg::result_t IHL_R   = '{16'd0, 16'd0, 7'd0, 16'd0, uhx_pkg::ST_BAD_IHL};
	localparam uhx_pkg::result_t NO_R    = '{16'd0, 16'd0, 7'd0, 16'd0, uhx_pkg::ST_OK};

	// Short frames whose outcome is fixed: early ends on the cooked and Ethernet link types, bad IHL on the loop type
	stim_row_t intro_rows [19] = '{
		'{8'hFF, 1'b1, 1'b1, TRUNC_R},
		'{8'h02, 1'b0, 1'b0, NO_R},
		'{8'h00, 1'b0, 1'b0, NO_R},
		'{8'hFF, 1'b0, 1'b0, NO_R},
		'{8'h00, 1'b0, 1'b0, NO_R},
		'{8'hF4, 1'b0, 1'b1, IHL_R},
		'{8'hAA, 1'b0, 1'b0, NO_R},
		'{8'h55, 1'b1, 1'b0, NO_R},
		'{8'h00, 1'b0, 1'b0, NO_R},
		'{8'h00, 1'b1, 1'b1, TRUNC_R},
		'{8'h02, 1'b0, 1'b0, NO_R},
		'{8'h01, 1'b0, 1'b0, NO_R},
		'{8'h80, 1'b0, 1'b0, NO_R},
		'{8'h7F, 1'b0, 1'b0, NO_R},
		'{8'h00, 1'b1, 1'b1, IHL_R},
		'{8'hFF, 1'b0, 1'b0, NO_R},
		'{8'h00, 1'b0, 1'b0, NO_R},
		'{8'h7F, 1'b0, 1'b0, NO_R},
		'{8'h80, 1'b1, 1'b1, TRUNC_R}
	};

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic [7:0]  frame_byte = 8'd0;
	logic        frame_end  = 1'b0;
	logic        out_ready  = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic [6:0]  payload_offset;
	logic [15:0] payload_size;
	logic [1:0]  status;

	// Predictor state
	logic [6:0]  pos_q;
	logic [4:0]  link_len;
	logic [5:0]  ip_len;
	logic [15:0] src_hold;
	logic [15:0] dst_hold;
	logic [15:0] len_hold;
	bit          header_done;

	uhx_pkg::result_t pending_headers[$];
	uhx_pkg::result_t head_want;
	logic [7:0]  frame_q[$];
	int          cycle_count = 0;
	int          errors = 0;
	int          bytes_sent = 0;
	int          frames_sent = 0;
	int          headers_seen = 0;
	int          status_count [4] = '{0, 0, 0, 0};
	bit          calm = 1'b0;

	udp_header_extractor dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.frame_byte     (frame_byte),
		.frame_end      (frame_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.source_port    (source_port),
		.dest_port      (dest_port),
		.payload_offset (payload_offset),
		.payload_size   (payload_size),
		.status         (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 33);
	end

	function automatic void clear_parser();
		pos_q       = 7'd0;
		link_len    = 5'd0;
		ip_len      = 6'd0;
		src_hold    = 16'd0;
		dst_hold    = 16'd0;
		len_hold    = 16'd0;
		header_done = 1'b0;
	endfunction

	// Advance the parser by one byte; return 1 when the byte yields a header result
	function automatic bit header_predict(input logic [7:0] b, input logic e,
			output uhx_pkg::result_t r);
		bit         found;
		logic [6:0] udp_base;
		int         idx;
		found = 1'b0;
		r = NO_R;
		if (!header_done) begin
			if (pos_q == 7'd0) begin
				link_len = (b == uhx_pkg::TAG_COOKED) ? uhx_pkg::LINK_COOKED_BYTES :
					(b == uhx_pkg::TAG_LOOP) ? uhx_pkg::LINK_LOOP_BYTES :
					uhx_pkg::LINK_ETH_BYTES;
			end else if (pos_q == 7'(link_len)) begin
				ip_len = {b[3:0], 2'b00};
				if (b[3:0] < uhx_pkg::MIN_IHL) begin
					r.status = uhx_pkg::ST_BAD_IHL;
					found = 1'b1;
				end
			end else if (pos_q > 7'(link_len)) begin
				udp_base = 7'(link_len) + 7'(ip_len);
				if (pos_q >= udp_base) begin
					idx = int'(pos_q - udp_base);
					case (idx)
						uhx_pkg::UDP_SRC_HI: src_hold[15:8] = b;
						uhx_pkg::UDP_SRC_LO: src_hold[7:0] = b;
						uhx_pkg::UDP_DST_HI: dst_hold[15:8] = b;
						uhx_pkg::UDP_DST_LO: dst_hold[7:0] = b;
						uhx_pkg::UDP_LEN_HI: len_hold[15:8] = b;
						uhx_pkg::UDP_LEN_LO: len_hold[7:0] = b;
						uhx_pkg::UDP_LAST: begin
							r.source_port = src_hold;
							r.dest_port = dst_hold;
							r.payload_offset = udp_base + uhx_pkg::UDP_HDR_BYTES;
							if (len_hold < 16'(uhx_pkg::UDP_HDR_BYTES)) begin
								r.status = uhx_pkg::ST_SHORT_UDP;
							end else begin
								r.payload_size = len_hold - 16'(uhx_pkg::UDP_HDR_BYTES);
							end
							found = 1'b1;
						end
						default: ;
					endcase
				end
			end
			if (!found && e) begin
				r.status = uhx_pkg::ST_TRUNC;
				found = 1'b1;
			end
			if (found)
				header_done = 1'b1;
			else
				pos_q = pos_q + 7'd1;
		end
		if (e)
			clear_parser();
		return found;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			headers_seen++;
			status_count[status]++;
			if (pending_headers.size() == 0) begin
				$error("unexpected result transfer, status %0d", status);
				errors++;
			end else begin
				head_want = pending_headers.pop_front();
				if (source_port !== head_want.source_port) begin
					$error("source_port expected %h actual %h", head_want.source_port, source_port);
					errors++;
				end
				if (dest_port !== head_want.dest_port) begin
					$error("dest_port expected %h actual %h", head_want.dest_port, dest_port);
					errors++;
				end
				if (payload_offset !== head_want.payload_offset) begin
					$error("payload_offset expected %0d actual %0d",
						head_want.payload_offset, payload_offset);
					errors++;
				end
				if (payload_size !== head_want.payload_size) begin
					$error("payload_size expected %0d actual %0d",
						head_want.payload_size, payload_size);
					errors++;
				end
				if (status !== head_want.status) begin
					$error("status expected %0d actual %0d", head_want.status, status);
					errors++;
				end
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer
	task automatic send_frame_byte(input logic [7:0] b, input logic e, input bit typed,
			input uhx_pkg::result_t want);
		uhx_pkg::result_t guess;
		bit               found;
		while (!calm && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		frame_byte <= b;
		frame_end <= e;
		do @(posedge clk); while (!in_ready);
		found = header_predict(b, e, guess);
		if (typed)
			pending_headers.push_back(want);
		else if (found)
			pending_headers.push_back(guess);
		bytes_sent++;
		if (e)
			frames_sent++;
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_headers.size() != 0);
	endtask

	function automatic logic [15:0] pick_port();
		case ($urandom_range(3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic build_frame();
		int         kind;
		int         link;
		int         ihl;
		int         cut;
		logic [7:0] tag;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [15:0] ulen;
		frame_q.delete();
		kind = $urandom_range(99);
		if (kind >= 92) begin
			// noise: short runs of random bytes
			repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
			return;
		end
		case ($urandom_range(2))
			0: tag = uhx_pkg::TAG_COOKED;
			1: tag = uhx_pkg::TAG_LOOP;
			default: tag = 8'($urandom);
		endcase
		link = (tag == uhx_pkg::TAG_COOKED) ? int'(uhx_pkg::LINK_COOKED_BYTES) :
			(tag == uhx_pkg::TAG_LOOP) ? int'(uhx_pkg::LINK_LOOP_BYTES) :
			int'(uhx_pkg::LINK_ETH_BYTES);
		frame_q.push_back(tag);
		repeat (link - 1) frame_q.push_back(8'($urandom));
		if (kind >= 84) begin
			ihl = $urandom_range(4);
			frame_q.push_back({4'($urandom), 4'(ihl)});
			repeat ($urandom_range(5)) frame_q.push_back(8'($urandom));
			return;
		end
		ihl = $urandom_range(1) ? 5 : $urandom_range(5, 15);
		frame_q.push_back({4'($urandom), 4'(ihl)});
		repeat (ihl * 4 - 1) frame_q.push_back(8'($urandom));
		sp = pick_port();
		dp = pick_port();
		case ($urandom_range(5))
			0: ulen = 16'($urandom_range(7));
			1: ulen = 16'd8;
			2: ulen = 16'($urandom_range(9, 64));
			3: ulen = 16'hFFFF;
			default: ulen = 16'($urandom);
		endcase
		frame_q.push_back(sp[15:8]);
		frame_q.push_back(sp[7:0]);
		frame_q.push_back(dp[15:8]);
		frame_q.push_back(dp[7:0]);
		frame_q.push_back(ulen[15:8]);
		frame_q.push_back(ulen[7:0]);
		repeat (2 + $urandom_range(6)) frame_q.push_back(8'($urandom));
		if (kind >= 70) begin
			// cut the frame short somewhere, possibly after the header
			cut = $urandom_range(1, frame_q.size());
			while (frame_q.size() > cut) void'(frame_q.pop_back());
		end
	endtask

	initial begin
		bit held;
		held = 1'b0;
		clear_parser();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (intro_rows[i])
			send_frame_byte(intro_rows[i].data, intro_rows[i].last, intro_rows[i].typed,
				intro_rows[i].want);
		hold_until_drained();

		while (bytes_sent < $size(intro_rows) + RANDOM_BYTES) begin
			calm = (bytes_sent >= 600 && bytes_sent < 900);
			if (!held && bytes_sent >= 1100) begin
				hold_until_drained();
				held = 1'b1;
			end
			build_frame();
			foreach (frame_q[i])
				send_frame_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, NO_R);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (pending_headers.size() != 0) @(negedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d frame bytes in %0d frames, checked %0d header results",
			bytes_sent, frames_sent, headers_seen);
		$display("by status: ok %0d, truncated %0d, short udp %0d, bad ihl %0d",
			status_count[uhx_pkg::ST_OK], status_count[uhx_pkg::ST_TRUNC],
			status_count[uhx_pkg::ST_SHORT_UDP], status_count[uhx_pkg::ST_BAD_IHL]);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
